### design/sbda_pkg.sv
// Shared types and constants for the signed binary to decimal ASCII converter.
package sbda_pkg;

   localparam int unsigned MAX_DIGITS = 10;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned COUNT_W    = 4;   // holds 0..MAX_DIGITS

   localparam logic [7:0]  CHAR_MINUS = 8'd45;
   localparam logic [7:0]  CHAR_ZERO  = 8'd48;

   // ceil(2^35 / 10): exact quotient for every 32-bit dividend via >> 35
   localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

### design/signed_binary_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// Request channel (req_valid/req_ready/req_value) takes one two's complement
// 32-bit integer per transfer. Response channel (rsp_valid/rsp_ready) returns
// its decimal text one ASCII character per transfer, most significant digit
// first, with a leading '-' for negative values; rsp_last marks the final
// character. Zero gives "0", the most negative value gives "-2147483648".
//
// Timing: after a request transfer the shared divide-by-ten unit runs once
// per cycle, giving one decimal digit each run (D = 1..10). Characters then
// leave at one per cycle while rsp_ready is high; an item sends D characters
// plus one for a sign. req_ready is high only while idle, so a new request
// is taken only after the last character of the previous one has left.
//
// Reset (synchronous, active high) returns to idle with nothing pending.
// A stalled receiver simply holds the current character; the sequencer
// waits and loses nothing.
module signed_binary_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);
   import sbda_pkg::*;

   state_type              state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic [31:0]            mag_ff, mag_in;

   stack_ctl_type          stack_ctl;
   logic [DIGIT_W-1:0]     top_digit;
   logic [COUNT_W-1:0]     digit_count;
   logic [31:0]            quotient;
   logic [DIGIT_W-1:0]     remainder;
   logic [31:0]            raw;

   // shared divide-by-ten unit, applied to the running magnitude
   sbda_div10 u_div10 (
      .dividend  (mag_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // digits come out LSB first from the divider, leave MSB first
   sbda_digit_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stack_ctl),
      .push_digit (remainder),
      .top_digit  (top_digit),
      .count      (digit_count)
   );

   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      stack_ctl     = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      rsp_character = CHAR_ZERO + 8'(top_digit);
      rsp_last      = 1'b0;
      raw           = 32'(req_value);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // magnitude as unsigned, so the most negative value needs no special case
               neg_in          = raw[31];
               mag_in          = raw[31] ? (32'd0 - raw) : raw;
               stack_ctl.clear = 1'b1;
               state_in        = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            stack_ctl.push = 1'b1;
            mag_in         = quotient;
            // a 32-bit magnitude never needs more than ten digits
            if (quotient == 32'd0 || digit_count == COUNT_W'(MAX_DIGITS - 1)) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_character = CHAR_MINUS;
            if (rsp_ready) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            rsp_valid = 1'b1;
            rsp_last  = (digit_count == COUNT_W'(1));
            if (rsp_ready) begin
               stack_ctl.pop = 1'b1;
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
   end

endmodule

### design/sbda_div10.sv
// Shared divide-by-ten unit: reciprocal multiply, quotient and remainder.
module sbda_div10 (
   input  logic [31:0]                  dividend,
   output logic [31:0]                  quotient,
   output logic [sbda_pkg::DIGIT_W-1:0] remainder
);
   import sbda_pkg::*;

   logic [63:0] product;
   logic [31:0] times_ten;

   always_comb begin
      product   = 64'(dividend) * 64'(RECIP_TEN);
      quotient  = 32'(product >> RECIP_SHIFT);
      times_ten = 32'(quotient << 3) + 32'(quotient << 1);
      remainder = DIGIT_W'(dividend - times_ten);
   end

endmodule

### design/sbda_digit_stack.sv
// Digit stack: digits pushed least significant first, popped most significant first.
module sbda_digit_stack (
   input  logic                          clock,
   input  logic                          reset,
   input  sbda_pkg::stack_ctl_type       ctl,
   input  logic [sbda_pkg::DIGIT_W-1:0]  push_digit,
   output logic [sbda_pkg::DIGIT_W-1:0]  top_digit,
   output logic [sbda_pkg::COUNT_W-1:0]  count
);
   import sbda_pkg::*;

   logic [DIGIT_W-1:0] digit_ff [MAX_DIGITS];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] top_idx;

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
      top_idx   = count_ff - COUNT_W'(1);
      top_digit = digit_ff[top_idx];
      count     = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // payload storage, no reset needed
   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.clear) begin
         digit_ff[count_ff] <= push_digit;
      end
   end

endmodule
